[sv/itoar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package itoar_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_CHARS_DEF  = 33;

    localparam int RADIX_W = 6;
    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 7;
    localparam int REM_W   = 5;   // remainder is always below the radix, at most 31

    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);

    localparam logic [MODE_W-1:0] MODE_SIGNED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPPER  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOWER  = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd32;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 7'd45;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               lower;
        logic               neg10;
        logic               bad;
    } t_job_ctl;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d,
                                                     input logic lower);
        logic [CHAR_W-1:0] base;
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-REM_W){1'b0}}, d};
        if (d < 5'd10) begin
            digit_char = ASCII_ZERO + dx;
        end else begin
            base = lower ? ASCII_LOWER_A : ASCII_UPPER_A;
            digit_char = base + dx - 7'd10;
        end
    endfunction

endpackage
`default_nettype wire

[sv/itoar_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module itoar_front #(
    parameter int VALUE_BITS = itoar_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire logic [VALUE_BITS-1:0]        i_number,
    input  wire logic [itoar_pkg::RADIX_W-1:0] i_radix,
    input  wire logic [itoar_pkg::MODE_W-1:0]  i_mode,
    output logic                              o_job_valid,
    output itoar_pkg::t_job_ctl               o_job_ctl,
    output logic [VALUE_BITS-1:0]             o_job_mag,
    input  wire logic                         i_job_ready
);

    localparam int FW = $clog2(itoar_pkg::QUEUE_DEPTH + 1);

    logic [VALUE_BITS-1:0]     r_q_mag [itoar_pkg::QUEUE_DEPTH];
    itoar_pkg::t_job_ctl       r_q_ctl [itoar_pkg::QUEUE_DEPTH];
    logic [itoar_pkg::QPW-1:0] r_wr_ptr;
    logic [itoar_pkg::QPW-1:0] r_rd_ptr;
    logic [FW-1:0]             r_fill;

    logic                      push;
    logic                      pop;
    logic                      negative;
    logic [VALUE_BITS-1:0]     mag;
    itoar_pkg::t_job_ctl       ctl;

    // classify the incoming transaction
    always_comb begin
        negative  = (i_mode == itoar_pkg::MODE_SIGNED) && i_number[VALUE_BITS-1];
        mag       = negative ? (~i_number + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : i_number;
        ctl.radix = i_radix;
        ctl.lower = (i_mode != itoar_pkg::MODE_SIGNED) && (i_mode != itoar_pkg::MODE_UPPER);
        ctl.neg10 = negative && (i_radix == itoar_pkg::RADIX_DEC);
        ctl.bad   = (i_radix < itoar_pkg::RADIX_MIN) || (i_radix > itoar_pkg::RADIX_MAX);
    end

    assign o_busy      = (r_fill == FW'(itoar_pkg::QUEUE_DEPTH));
    assign push        = i_start && !o_busy;
    assign o_job_valid = (r_fill != '0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job_ctl   = r_q_ctl[r_rd_ptr];
    assign o_job_mag   = r_q_mag[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mag[r_wr_ptr] <= mag;
            r_q_ctl[r_wr_ptr] <= ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[sv/itoar_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module itoar_back #(
    parameter int VALUE_BITS = itoar_pkg::VALUE_BITS_DEF,
    parameter int MAX_CHARS  = itoar_pkg::MAX_CHARS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_job_valid,
    input  wire itoar_pkg::t_job_ctl          i_job_ctl,
    input  wire logic [VALUE_BITS-1:0]        i_job_mag,
    output logic                              o_job_ready,
    output logic                              o_valid,
    output logic [itoar_pkg::CHAR_W-1:0]      o_character,
    output logic                              o_last,
    output logic                              o_bad_radix
);

    localparam int CYC = (VALUE_BITS + 7) / 8;   // 8 quotient bits per cycle
    localparam int QW  = CYC * 8;
    localparam int STW = (CYC > 1) ? $clog2(CYC) : 1;
    localparam int AW  = $clog2(MAX_CHARS);
    localparam int CW  = $clog2(MAX_CHARS + 1);
    localparam int RW  = itoar_pkg::REM_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_FIN  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [QW-1:0]                  r_quo, n_quo;
    logic [RW-1:0]                  r_rem, n_rem;
    logic [STW-1:0]                 r_step, n_step;
    logic [CW-1:0]                  r_count, n_count;
    logic [AW-1:0]                  r_rd_ptr, n_rd_ptr;
    logic [itoar_pkg::RADIX_W-1:0]  r_radix, n_radix;
    logic                           r_lower, n_lower;
    logic                           r_neg10, n_neg10;
    logic                           r_emit_vld, n_emit_vld;
    logic                           r_emit_last, n_emit_last;
    logic                           r_emit_bad, n_emit_bad;

    logic [itoar_pkg::CHAR_W-1:0]   r_mem [MAX_CHARS];
    logic [itoar_pkg::CHAR_W-1:0]   r_mem_q;
    logic                           mem_we;
    logic [AW-1:0]                  mem_wa;
    logic [itoar_pkg::CHAR_W-1:0]   mem_wd;
    logic                           rd_en;

    logic [QW-1:0]                  d_quo;
    logic [RW-1:0]                  d_rem;
    logic [RW:0]                    tmp;

    // 8 restoring-division steps on the 5-bit remainder
    always_comb begin
        d_quo = r_quo;
        d_rem = r_rem;
        tmp   = '0;
        for (int i = 0; i < 8; i++) begin
            tmp   = {d_rem, d_quo[QW-1]};
            d_quo = {d_quo[QW-2:0], 1'b0};
            if (tmp >= r_radix) begin
                tmp      = tmp - r_radix;
                d_quo[0] = 1'b1;
            end
            d_rem = tmp[RW-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_step      = r_step;
        n_count     = r_count;
        n_rd_ptr    = r_rd_ptr;
        n_radix     = r_radix;
        n_lower     = r_lower;
        n_neg10     = r_neg10;
        n_emit_vld  = 1'b0;
        n_emit_last = r_emit_last;
        n_emit_bad  = r_emit_bad;
        mem_we      = 1'b0;
        mem_wa      = r_count[AW-1:0];
        mem_wd      = itoar_pkg::digit_char(d_rem, r_lower);
        rd_en       = 1'b0;
        o_job_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    if (i_job_ctl.bad) begin
                        n_emit_vld  = 1'b1;
                        n_emit_last = 1'b1;
                        n_emit_bad  = 1'b1;
                    end else begin
                        n_quo   = {{(QW-VALUE_BITS){1'b0}}, i_job_mag};
                        n_rem   = '0;
                        n_step  = '0;
                        n_count = '0;
                        n_radix = i_job_ctl.radix;
                        n_lower = i_job_ctl.lower;
                        n_neg10 = i_job_ctl.neg10;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if ((r_step == '0) && ((r_quo == '0) || (r_count == CW'(MAX_CHARS)))) begin
                    n_state = S_FIN;
                end else begin
                    n_quo = d_quo;
                    n_rem = d_rem;
                    if (r_step == STW'(CYC - 1)) begin
                        mem_we  = 1'b1;
                        n_count = r_count + 1'b1;
                        n_step  = '0;
                        n_rem   = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (r_count == '0) begin
                    mem_we  = 1'b1;
                    mem_wd  = itoar_pkg::ASCII_ZERO;
                    n_count = CW'(1);
                end else if (r_neg10 && (r_count < CW'(MAX_CHARS))) begin
                    mem_we  = 1'b1;
                    mem_wd  = itoar_pkg::ASCII_MINUS;
                    n_count = r_count + 1'b1;
                end
                n_rd_ptr = AW'(n_count - 1'b1);
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                // stack read, most significant character first
                rd_en       = 1'b1;
                n_emit_vld  = 1'b1;
                n_emit_last = (r_rd_ptr == '0);
                n_emit_bad  = 1'b0;
                if (r_rd_ptr == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_rd_ptr = r_rd_ptr - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_mem_q <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_count    <= '0;
            r_quo      <= '0;
            r_emit_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_count    <= n_count;
            r_quo      <= n_quo;
            r_emit_vld <= n_emit_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_rd_ptr    <= n_rd_ptr;
        r_radix     <= n_radix;
        r_lower     <= n_lower;
        r_neg10     <= n_neg10;
        r_emit_last <= n_emit_last;
        r_emit_bad  <= n_emit_bad;
    end

    assign o_valid     = r_emit_vld;
    assign o_last      = r_emit_last;
    assign o_bad_radix = r_emit_bad;
    assign o_character = r_emit_bad ? '0 : r_mem_q;

endmodule
`default_nettype wire

[sv/integer_to_ascii_radix.sv]
`timescale 1ns / 1ps
`default_nettype none
// Integer to ASCII conversion in radix 2..32.
// Input: a transaction is taken when start is high and busy is low; it carries
// i_number, i_radix and i_mode (0 signed, 1 uppercase letters, 2 or 3 lowercase).
// A two-entry queue sits between the classifier and the converter, so busy only
// rises when two transactions are waiting behind the one being converted.
// Output: one character per cycle on o_character, strobed by o_valid, most
// significant first, o_last on the final one. Characters of one conversion come
// in consecutive cycles. A radix outside 2..32 gives one strobe with
// o_bad_radix and o_last set and o_character zero. The receiver cannot stall.
// Sequence: the converter takes a transaction in its idle state, then the
// shared divider (8 restoring steps per cycle) produces the digits, least
// significant first, until the quotient is zero or the stack is full; a final
// state places '0' for a zero value or '-' for a negative decimal value, and the
// characters are then emitted. No new transaction is taken while converting or
// emitting; a bad radix is answered from the idle state without division.
// Reset (synchronous, active low) empties the queue and idles the converter;
// no clearing pass is needed.
module integer_to_ascii_radix #(
    parameter int VALUE_BITS = itoar_pkg::VALUE_BITS_DEF,
    parameter int MAX_CHARS  = itoar_pkg::MAX_CHARS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [VALUE_BITS-1:0]         i_number,
    input  wire logic [itoar_pkg::RADIX_W-1:0] i_radix,
    input  wire logic [itoar_pkg::MODE_W-1:0]  i_mode,
    output logic                               o_valid,
    output logic [itoar_pkg::CHAR_W-1:0]       o_character,
    output logic                               o_last,
    output logic                               o_bad_radix
);

    logic                  job_valid;
    logic                  job_ready;
    itoar_pkg::t_job_ctl   job_ctl;
    logic [VALUE_BITS-1:0] job_mag;

    itoar_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_number   (i_number),
        .i_radix    (i_radix),
        .i_mode     (i_mode),
        .o_job_valid(job_valid),
        .o_job_ctl  (job_ctl),
        .o_job_mag  (job_mag),
        .i_job_ready(job_ready)
    );

    itoar_back #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(job_valid),
        .i_job_ctl  (job_ctl),
        .i_job_mag  (job_mag),
        .o_job_ready(job_ready),
        .o_valid    (o_valid),
        .o_character(o_character),
        .o_last     (o_last),
        .o_bad_radix(o_bad_radix)
    );

endmodule
`default_nettype wire

[sv/itoar_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module itoar_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         o_valid,
    input wire logic [itoar_pkg::CHAR_W-1:0] o_character,
    input wire logic                         o_last,
    input wire logic                         o_bad_radix
);

    // error transaction is a single zero character
    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_radix |-> o_last && (o_character == '0))
        else $error("bad radix strobe malformed");

    // characters of one conversion are streamed without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid && !o_bad_radix)
        else $error("gap inside a conversion");

    // a minus sign always leads digits
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_radix && (o_character == itoar_pkg::ASCII_MINUS) |-> !o_last)
        else $error("minus sign without digits");

    // queue fills only through an accepted transaction
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a transaction");

endmodule

bind integer_to_ascii_radix itoar_checker u_itoar_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_character(o_character),
    .o_last     (o_last),
    .o_bad_radix(o_bad_radix)
);
`default_nettype wire

[dv/tb_integer_to_ascii_radix.sv]
`timescale 1ns / 1ps
module tb_integer_to_ascii_radix;

    localparam int NUM_W = itoar_pkg::VALUE_BITS_DEF;
    localparam int RW    = itoar_pkg::RADIX_W;
    localparam int MW    = itoar_pkg::MODE_W;
    localparam int CHW   = itoar_pkg::CHAR_W;
    localparam logic [MW-1:0] MODE_LOWER_ALT = 2'd3;  // unused code, acts as lowercase
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_PER_PHASE = 112;

    typedef struct {
        logic [NUM_W-1:0] number;
        logic [RW-1:0]    radix;
        logic [MW-1:0]    mode;
    } t_conv_req;

    typedef struct packed {
        logic [CHW-1:0] ch;
        logic           last;
        logic           bad;
    } t_char;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [NUM_W-1:0] i_number;
    logic [RW-1:0]    i_radix;
    logic [MW-1:0]    i_mode;
    logic             o_valid;
    logic [CHW-1:0]   o_character;
    logic             o_last;
    logic             o_bad_radix;

    t_conv_req pending_reqs[$];
    t_char     expected_chars[$];
    t_conv_req active_req;
    t_char     want;
    int        sender_idle_pct;
    int        reqs_queued;
    int        reqs_taken;
    int        mismatches;
    int        quiet_cycles;

    integer_to_ascii_radix dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_number    (i_number),
        .i_radix     (i_radix),
        .i_mode      (i_mode),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last),
        .o_bad_radix (o_bad_radix)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Expected characters of one conversion, most significant first.
    task automatic predict_chars(input t_conv_req req);
        logic [NUM_W-1:0] mag;
        logic [NUM_W-1:0] rem;
        logic [CHW-1:0]   digits[$];
        logic             neg;
        logic             lower;
        t_char            c;
        if (req.radix < itoar_pkg::RADIX_MIN || req.radix > itoar_pkg::RADIX_MAX) begin
            c.ch   = '0;
            c.last = 1'b1;
            c.bad  = 1'b1;
            expected_chars.push_back(c);
            return;
        end
        neg   = (req.mode == itoar_pkg::MODE_SIGNED) && req.number[NUM_W-1];
        lower = (req.mode == itoar_pkg::MODE_LOWER) || (req.mode == MODE_LOWER_ALT);
        mag   = neg ? (~req.number + 1'b1) : req.number;
        while (mag != '0) begin
            rem = mag % req.radix;
            if (rem < 10)
                digits.push_back(itoar_pkg::ASCII_ZERO + CHW'(rem));
            else
                digits.push_back((lower ? itoar_pkg::ASCII_LOWER_A : itoar_pkg::ASCII_UPPER_A)
                                 + CHW'(rem - 10));
            mag = mag / req.radix;
        end
        if (digits.size() == 0)
            digits.push_back(itoar_pkg::ASCII_ZERO);
        if (neg && req.radix == itoar_pkg::RADIX_DEC)
            digits.push_back(itoar_pkg::ASCII_MINUS);
        for (int k = digits.size() - 1; k >= 0; k--) begin
            c.ch   = digits[k];
            c.last = (k == 0);
            c.bad  = 1'b0;
            expected_chars.push_back(c);
        end
    endtask

    task automatic push_req(input logic [NUM_W-1:0] number, input logic [RW-1:0] radix,
                            input logic [MW-1:0] mode);
        t_conv_req r;
        r.number = number;
        r.radix  = radix;
        r.mode   = mode;
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic wait_drained();
        while (!(reqs_taken == reqs_queued && expected_chars.size() == 0))
            @(posedge i_clk);
    endtask

    function automatic logic [NUM_W-1:0] rand_number();
        case ($urandom_range(5, 0))
            0: rand_number = NUM_W'($urandom_range(40, 0));
            1: rand_number = $urandom;
            2: rand_number = {NUM_W{1'b1}} - NUM_W'($urandom_range(20, 0));
            3: rand_number = {1'b1, {(NUM_W-1){1'b0}}} + NUM_W'($urandom_range(20, 0));
            4: rand_number = NUM_W'(1) << $urandom_range(NUM_W - 1, 0);
            default: rand_number = $urandom >> $urandom_range(NUM_W - 1, 0);
        endcase
    endfunction

    function automatic logic [RW-1:0] rand_radix();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 4)
            rand_radix = RW'($urandom_range(1, 0));
        else if (pick < 10)
            rand_radix = RW'($urandom_range(63, 33));
        else if (pick < 35)
            rand_radix = itoar_pkg::RADIX_DEC;
        else
            rand_radix = RW'($urandom_range(32, 2));
    endfunction

    task automatic report_mismatch(input string what, input t_char exp_c);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: char exp %0d got %0d, last exp %0b got %0b, bad exp %0b got %0b",
                     $realtime, what, exp_c.ch, o_character, exp_c.last, o_last,
                     exp_c.bad, o_bad_radix);
    endtask

    // Driver: a transaction is taken when start is high and busy is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_chars(active_req);
                reqs_taken++;
            end
            if (!start || !busy) begin
                if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                    active_req = pending_reqs.pop_front();
                    start    <= 1'b1;
                    i_number <= active_req.number;
                    i_radix  <= active_req.radix;
                    i_mode   <= active_req.mode;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe is a result that cannot be held off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_chars.size() == 0) begin
                want = '0;
                report_mismatch("unexpected character", want);
            end else begin
                want = expected_chars.pop_front();
                if (o_character !== want.ch || o_last !== want.last || o_bad_radix !== want.bad)
                    report_mismatch("mismatch", want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_integer_to_ascii_radix NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int idle_plan[4];
        idle_plan = '{0, 56, 0, 12};
        i_rst_n = 1'b0;
        start = 1'b0;
        i_number = '0;
        i_radix = '0;
        i_mode = '0;
        sender_idle_pct = 0;
        reqs_queued = 0;
        reqs_taken = 0;
        mismatches = 0;
        quiet_cycles = 0;

        // Directed: zero, extremes, most negative, sign rules, letters, bad radix.
        push_req('0, itoar_pkg::RADIX_DEC, itoar_pkg::MODE_SIGNED);
        push_req('0, 6'd2, itoar_pkg::MODE_UPPER);
        push_req('0, itoar_pkg::RADIX_MAX, itoar_pkg::MODE_LOWER);
        push_req({NUM_W{1'b1}}, itoar_pkg::RADIX_MIN, itoar_pkg::MODE_UPPER);
        push_req({NUM_W{1'b1}}, itoar_pkg::RADIX_MAX, itoar_pkg::MODE_UPPER);
        push_req({NUM_W{1'b1}}, itoar_pkg::RADIX_MAX, itoar_pkg::MODE_LOWER);
        push_req({NUM_W{1'b1}}, itoar_pkg::RADIX_DEC, itoar_pkg::MODE_SIGNED);
        push_req({NUM_W{1'b1}}, 6'd16, itoar_pkg::MODE_SIGNED);
        push_req({1'b1, {(NUM_W-1){1'b0}}}, itoar_pkg::RADIX_DEC, itoar_pkg::MODE_SIGNED);
        push_req({1'b1, {(NUM_W-1){1'b0}}}, itoar_pkg::RADIX_MIN, itoar_pkg::MODE_SIGNED);
        push_req({1'b1, {(NUM_W-1){1'b0}}}, itoar_pkg::RADIX_DEC, itoar_pkg::MODE_UPPER);
        push_req({1'b0, {(NUM_W-1){1'b1}}}, itoar_pkg::RADIX_DEC, itoar_pkg::MODE_SIGNED);
        push_req(32'hDEADBEEF, 6'd16, MODE_LOWER_ALT);
        push_req(32'hDEADBEEF, 6'd16, itoar_pkg::MODE_UPPER);
        push_req(32'd35, 6'd36, itoar_pkg::MODE_UPPER);
        push_req(32'd31, itoar_pkg::RADIX_MAX, itoar_pkg::MODE_SIGNED);
        push_req(32'd31, itoar_pkg::RADIX_MAX, itoar_pkg::MODE_LOWER);
        push_req(32'd9, itoar_pkg::RADIX_DEC, itoar_pkg::MODE_UPPER);
        push_req(32'd1, 6'd3, itoar_pkg::MODE_SIGNED);
        push_req(32'd123, 6'd0, itoar_pkg::MODE_SIGNED);
        push_req(32'd123, 6'd1, itoar_pkg::MODE_LOWER);
        push_req(32'd123, 6'd33, itoar_pkg::MODE_UPPER);
        push_req(32'd123, 6'd63, MODE_LOWER_ALT);
        push_req(32'hFFFFFFF6, itoar_pkg::RADIX_DEC, itoar_pkg::MODE_SIGNED);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            @(posedge i_clk);
            sender_idle_pct = idle_plan[phase];
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                push_req(rand_number(), rand_radix(), MW'($urandom_range(3, 0)));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("tb_integer_to_ascii_radix OK");
        else
            $display("tb_integer_to_ascii_radix NOT OK");
        $finish;
    end

endmodule

[files.f]
sv/itoar_pkg.sv
sv/itoar_front.sv
sv/itoar_back.sv
sv/integer_to_ascii_radix.sv
sv/itoar_checker.sv
dv/tb_integer_to_ascii_radix.sv
